// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/htsed_pkg.sv
// ----------------------------------------------------------------------------
// htsed_pkg
// character constants, entity names and helpers for the tag stripper
// ----------------------------------------------------------------------------
package htsed_pkg;

	// special characters of the source text
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_P    = 8'h70;
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_QUOT = 8'h22;

	// entity names, first character in the top byte
	localparam logic [23:0] NAME_AMP  = "amp";
	localparam logic [31:0] NAME_APOS = "apos";
	localparam logic [15:0] NAME_LT   = "lt";
	localparam logic [15:0] NAME_GT   = "gt";
	localparam logic [31:0] NAME_QUOT = "quot";

	// ascii upper case to lower case, everything else unchanged
	function automatic logic [7:0] fold_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

endpackage

// File: rtl/htsed_entity_dec.sv
// ----------------------------------------------------------------------------
// htsed_entity_dec
// case-insensitive lookup of a collected entity name
// ----------------------------------------------------------------------------
module htsed_entity_dec #(
	parameter int ENTITY_CHARS = 4
) (
	input  logic [ENTITY_CHARS-1:0][7:0]       name_buf,
	input  logic [$clog2(ENTITY_CHARS+1)-1:0]  name_len,
	input  logic                               name_ovf,
	output logic [7:0]                         dec_char
);

	localparam int LEN_W = $clog2(ENTITY_CHARS + 1);

	logic [7:0] f0, f1, f2, f3;
	logic       len2, len3, len4;

	// folded first four name bytes
	assign f0 = htsed_pkg::fold_lower(name_buf[0]);
	assign f1 = htsed_pkg::fold_lower(name_buf[1]);
	assign f2 = htsed_pkg::fold_lower(name_buf[2]);
	assign f3 = htsed_pkg::fold_lower(name_buf[3]);

	// length qualifiers, an overflowed name never matches
	assign len2 = !name_ovf && (name_len == LEN_W'(2));
	assign len3 = !name_ovf && (name_len == LEN_W'(3));
	assign len4 = !name_ovf && (name_len == LEN_W'(4));

	// name table, unknown names give ampersand
	always_comb begin
		if (len3 && {f0, f1, f2} == htsed_pkg::NAME_AMP) begin
			dec_char = htsed_pkg::CH_AMP;
		end else if (len4 && {f0, f1, f2, f3} == htsed_pkg::NAME_APOS) begin
			dec_char = htsed_pkg::CH_APOS;
		end else if (len2 && {f0, f1} == htsed_pkg::NAME_LT) begin
			dec_char = htsed_pkg::CH_LT;
		end else if (len2 && {f0, f1} == htsed_pkg::NAME_GT) begin
			dec_char = htsed_pkg::CH_GT;
		end else if (len4 && {f0, f1, f2, f3} == htsed_pkg::NAME_QUOT) begin
			dec_char = htsed_pkg::CH_QUOT;
		end else begin
			dec_char = htsed_pkg::CH_AMP;
		end
	end

endmodule

// File: rtl/html_tag_strip_entity_decode_top.sv
// ----------------------------------------------------------------------------
// html_tag_strip_entity_decode_top
// strips markup tags and decodes named entities, one character per transfer
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  input   | in_valid / in_stall  | ch, last
//  output  | out_valid / out_stall| out_char, char_valid, end_of_text
//
//  one character per cycle sustained while out_stall is low; an accepted
//  character is held in the input register, and its result is loaded into
//  the result register when the input register advances. the mode machine
//  and the four-byte name compare sit between the two registers. arst_n
//  clears mode state and both valid flags; the name buffer has no reset.
//  in_stall rises only when the result register holds a stalled result and
//  the input register is also full.
`include "assert_macros.svh"

module html_tag_strip_entity_decode_top #(
	parameter int ENTITY_CHARS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       end_of_text
);

	localparam int LEN_W = $clog2(ENTITY_CHARS + 1);
	localparam int IDX_W = $clog2(ENTITY_CHARS);

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_TAG_START,
		MODE_IN_TAG,
		MODE_ENTITY
	} mode_t;

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	// scan state
	mode_t                          mode_q, mode_nxt;
	logic                           seen_any_q;
	logic                           tnf_q, tnf_nxt;
	logic [LEN_W-1:0]               len_q, len_nxt;
	logic                           ovf_q, ovf_nxt;
	logic [ENTITY_CHARS-1:0][7:0]   name_q, name_nxt;

	// result register
	logic       valid_s2;
	logic [7:0] char_s2;
	logic       cval_s2;
	logic       eot_s2;

	logic       out_free;
	logic       advance;
	logic       wr_en;
	logic       emit;
	logic       use_dec;
	logic [7:0] oc;
	logic [7:0] dec_char;
	logic [7:0] res_char;

	// flow control
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// input register, loads whenever it is not held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	// mode machine next state and emitted character
	always_comb begin
		mode_nxt = mode_q;
		tnf_nxt  = tnf_q;
		len_nxt  = len_q;
		ovf_nxt  = ovf_q;
		wr_en    = 1'b0;
		emit     = 1'b0;
		use_dec  = 1'b0;
		oc       = ch_s1;
		case (mode_q)
			MODE_TEXT: begin
				if (ch_s1 == htsed_pkg::CH_LT) begin
					tnf_nxt  = seen_any_q;
					mode_nxt = MODE_TAG_START;
				end else if (ch_s1 == htsed_pkg::CH_AMP) begin
					len_nxt  = '0;
					ovf_nxt  = 1'b0;
					mode_nxt = MODE_ENTITY;
					if (last_s1) begin
						emit    = 1'b1;
						use_dec = 1'b1;
					end
				end else begin
					emit = 1'b1;
				end
			end
			MODE_TAG_START: begin
				if (ch_s1 == htsed_pkg::CH_P && tnf_q) begin
					emit = 1'b1;
					oc   = htsed_pkg::CH_NL;
				end
				mode_nxt = (ch_s1 == htsed_pkg::CH_GT) ? MODE_TEXT : MODE_IN_TAG;
			end
			MODE_IN_TAG: begin
				if (ch_s1 == htsed_pkg::CH_GT) begin
					mode_nxt = MODE_TEXT;
				end
			end
			MODE_ENTITY: begin
				if (ch_s1 == htsed_pkg::CH_SEMI) begin
					emit     = 1'b1;
					use_dec  = 1'b1;
					mode_nxt = MODE_TEXT;
				end else begin
					if (len_q < LEN_W'(ENTITY_CHARS)) begin
						wr_en   = 1'b1;
						len_nxt = len_q + LEN_W'(1);
					end else begin
						ovf_nxt = 1'b1;
					end
					if (last_s1) begin
						emit    = 1'b1;
						use_dec = 1'b1;
					end
				end
			end
			default: begin
				mode_nxt = MODE_TEXT;
			end
		endcase
	end

	// name buffer with the current byte merged in
	always_comb begin
		for (int k = 0; k < ENTITY_CHARS; k++) begin
			name_nxt[k] = (wr_en && len_q[IDX_W-1:0] == IDX_W'(k)) ? ch_s1 : name_q[k];
		end
	end

	// entity lookup on the updated name
	htsed_entity_dec #(
		.ENTITY_CHARS (ENTITY_CHARS)
	) u_entity_dec (
		.name_buf (name_nxt),
		.name_len (len_nxt),
		.name_ovf (ovf_nxt),
		.dec_char (dec_char)
	);

	assign res_char = !emit ? 8'h00 : (use_dec ? dec_char : oc);

	// scan state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_TEXT;
			seen_any_q <= 1'b0;
			tnf_q      <= 1'b0;
			len_q      <= '0;
			ovf_q      <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (advance) begin
				if (last_s1) begin
					mode_q     <= MODE_TEXT;
					seen_any_q <= 1'b0;
					tnf_q      <= 1'b0;
					len_q      <= '0;
					ovf_q      <= 1'b0;
				end else begin
					mode_q     <= mode_nxt;
					seen_any_q <= 1'b1;
					tnf_q      <= tnf_nxt;
					len_q      <= len_nxt;
					ovf_q      <= ovf_nxt;
				end
			end
			if (out_free) begin
				valid_s2 <= advance && (emit || last_s1);
			end
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			char_s2 <= res_char;
			cval_s2 <= emit;
			eot_s2  <= last_s1;
		end
	end

	// name byte store
	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			name_q <= name_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign out_char    = char_s2;
	assign char_valid  = cval_s2;
	assign end_of_text = eot_s2;

	// checks
	`ASSERT_NEXT(a_end_clears, advance && last_s1,
		mode_q == MODE_TEXT && len_q == '0 && !seen_any_q && !ovf_q,
		"state not cleared after end of text")
	`ASSERT_ALWAYS(a_len_bound, len_q <= LEN_W'(ENTITY_CHARS),
		"entity length beyond buffer")
	`ASSERT_ALWAYS(a_ovf_full, !ovf_q || len_q == LEN_W'(ENTITY_CHARS),
		"overflow flagged with buffer not full")
	`ASSERT_ALWAYS(a_result_reason, !valid_s2 || cval_s2 || eot_s2,
		"empty result without end of text")

endmodule
